/* design/sspq_pkg.sv */
// ----------------------------------------------------------------------------
// Stable sorted priority queue package
// Shared sizes, request and status codes, and the cell types of the queue.
// ----------------------------------------------------------------------------
package sspq_pkg;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned DATA_WIDTH     = 16;
  localparam int unsigned PRIORITY_WIDTH = 8;
  localparam int unsigned CNT_W          = $clog2(DEPTH + 1);
  localparam int unsigned KIND_W         = 3;
  localparam int unsigned STATUS_W       = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT    = 3'd0,
    KIND_DEL_GROUP = 3'd1,
    KIND_DEL_MATCH = 3'd2,
    KIND_CLEAR     = 3'd3,
    KIND_READ_ALL  = 3'd4,
    KIND_READ_PRIO = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_ROTATE = 3'd3,
    OP_CLEAR  = 3'd4
  } cell_op_e;

  typedef struct packed {
    logic                             valid;
    logic signed [DATA_WIDTH-1:0]     data;
    logic        [PRIORITY_WIDTH-1:0] prio;
  } entry_t;

  typedef struct packed {
    cell_op_e                         op;
    logic                             use_data;
    logic signed [DATA_WIDTH-1:0]     data;
    logic        [PRIORITY_WIDTH-1:0] prio;
  } cell_cmd_t;

endpackage

/* design/sspq_if.sv */
// ----------------------------------------------------------------------------
// Stable sorted priority queue channels
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sspq_in_if;
  import sspq_pkg::*;

  logic                             valid;
  logic                             ready;
  logic        [KIND_W-1:0]         kind;
  logic signed [DATA_WIDTH-1:0]     item_data;
  logic        [PRIORITY_WIDTH-1:0] item_priority;

  modport source (output valid, kind, item_data, item_priority, input ready);
  modport sink   (input valid, kind, item_data, item_priority, output ready);
endinterface

interface sspq_out_if;
  import sspq_pkg::*;

  logic                             valid;
  logic                             ready;
  logic        [STATUS_W-1:0]       status;
  logic signed [DATA_WIDTH-1:0]     out_data;
  logic        [PRIORITY_WIDTH-1:0] out_priority;
  logic        [CNT_W-1:0]          entry_count;
  logic                             last;

  modport source (output valid, status, out_data, out_priority, entry_count, last,
                  input ready);
  modport sink   (input valid, status, out_data, out_priority, entry_count, last,
                  output ready);
endinterface

/* design/sspq_cell.sv */
// ----------------------------------------------------------------------------
// Queue cell
// Holds one entry and loads from its left neighbor, its right neighbor,
// the head of the row or the new entry, as the broadcast command says.
// ----------------------------------------------------------------------------
module sspq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sspq_pkg::cell_cmd_t cmd_i,
  input  sspq_pkg::entry_t   left_i,
  input  sspq_pkg::entry_t   right_i,
  input  sspq_pkg::entry_t   head_i,
  input  logic               ins_prev_i,
  input  logic               hit_prev_i,
  output logic               ins_o,
  output logic               hit_o,
  output sspq_pkg::entry_t   entry_o
);
  import sspq_pkg::*;

  logic                             valid_q, valid_d;
  logic signed [DATA_WIDTH-1:0]     data_q, data_d;
  logic        [PRIORITY_WIDTH-1:0] prio_q, prio_d;
  logic                             match;

  // The row is sorted, so the insert marks form one run that reaches the end.
  assign ins_o = !valid_q || (prio_q > cmd_i.prio);
  assign match = valid_q && (prio_q == cmd_i.prio) &&
                 (!cmd_i.use_data || (data_q == cmd_i.data));
  assign hit_o = hit_prev_i || match;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    prio_d  = prio_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (ins_o && !ins_prev_i) begin
          valid_d = 1'b1;
          data_d  = cmd_i.data;
          prio_d  = cmd_i.prio;
        end else if (ins_o) begin
          valid_d = left_i.valid;
          data_d  = left_i.data;
          prio_d  = left_i.prio;
        end
      end
      OP_REMOVE: begin
        if (hit_o) begin
          valid_d = right_i.valid;
          data_d  = right_i.data;
          prio_d  = right_i.prio;
        end
      end
      OP_ROTATE: begin
        // The last valid cell takes the head word, the others shift left.
        if (valid_q && right_i.valid) begin
          data_d = right_i.data;
          prio_d = right_i.prio;
        end else if (valid_q) begin
          data_d = head_i.data;
          prio_d = head_i.prio;
        end
      end
      OP_CLEAR: valid_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.data  = data_q;
  assign entry_o.prio  = prio_q;

endmodule

/* design/sspq_chain.sv */
// ----------------------------------------------------------------------------
// Queue cell row
// Connects the cells to their neighbors and shows the first two entries
// and whether any cell matches the current command.
// ----------------------------------------------------------------------------
module sspq_chain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sspq_pkg::cell_cmd_t cmd_i,
  output sspq_pkg::entry_t    head_o,
  output sspq_pkg::entry_t    second_o,
  output logic                hit_o
);
  import sspq_pkg::*;

  localparam entry_t NO_ENTRY = '0;

  entry_t entries  [DEPTH];
  entry_t left_w   [DEPTH];
  entry_t right_w  [DEPTH];
  logic   ins      [DEPTH];
  logic   ins_prev [DEPTH];
  logic   hit      [DEPTH];
  logic   hit_prev [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g]   = NO_ENTRY;
      assign ins_prev[g] = 1'b0;
      assign hit_prev[g] = 1'b0;
    end else begin : g_inner
      assign left_w[g]   = entries[g-1];
      assign ins_prev[g] = ins[g-1];
      assign hit_prev[g] = hit[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign right_w[g] = NO_ENTRY;
    end else begin : g_mid
      assign right_w[g] = entries[g+1];
    end

    sspq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd_i),
      .left_i     (left_w[g]),
      .right_i    (right_w[g]),
      .head_i     (entries[0]),
      .ins_prev_i (ins_prev[g]),
      .hit_prev_i (hit_prev[g]),
      .ins_o      (ins[g]),
      .hit_o      (hit[g]),
      .entry_o    (entries[g])
    );
  end

  assign head_o   = entries[0];
  assign second_o = entries[1];
  assign hit_o    = hit[DEPTH-1];

endmodule

/* design/stable_sorted_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// Stable sorted priority queue
// Keeps entries in a row of cells in ascending priority, equal priorities in
// arrival order. Updates act on all cells at once; reads rotate the row.
// ----------------------------------------------------------------------------
// A request is taken when idle and executed once the result register is free,
// which registers the single result word of insert, delete match, clear and
// unknown kinds. Delete group removes one entry of the group per cycle before
// it reports. Reads rotate the cell row once per cycle while the result can be
// taken and list every entry, or every entry of the priority. Reset clears all
// valid marks and the count at once.
module stable_sorted_priority_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  sspq_in_if.sink     in_i,
  sspq_out_if.source  out_o
);
  import sspq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_GROUP = 2'd2;
  localparam logic [1:0] S_ROT   = 2'd3;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  logic [1:0]                       state_q, state_d;
  logic [KIND_W-1:0]                kind_q;
  logic signed [DATA_WIDTH-1:0]     data_q;
  logic        [PRIORITY_WIDTH-1:0] prio_q;
  logic [CNT_W-1:0]                 count_q, count_d;
  logic [CNT_W-1:0]                 step_q, step_d;
  logic                             found_q, found_d;

  logic                             out_valid_q;
  logic [STATUS_W-1:0]              out_status_q;
  logic signed [DATA_WIDTH-1:0]     out_data_q;
  logic        [PRIORITY_WIDTH-1:0] out_prio_q;
  logic [CNT_W-1:0]                 out_count_q;
  logic                             out_last_q;

  logic                             emit;
  status_e                          emit_status;
  logic signed [DATA_WIDTH-1:0]     emit_data;
  logic        [PRIORITY_WIDTH-1:0] emit_prio;
  logic                             emit_last;

  logic      can_emit;
  logic      in_fire;
  logic      hit;
  logic      head_sel;
  logic      at_end;
  cell_op_e  cmd_op;
  cell_cmd_t cmd;
  entry_t    head;
  entry_t    second;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign can_emit   = !out_valid_q || out_o.ready;

  assign cmd = '{op:       cmd_op,
                 use_data: (kind_q == KIND_DEL_MATCH),
                 data:     data_q,
                 prio:     prio_q};

  sspq_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .head_o   (head),
    .second_o (second),
    .hit_o    (hit)
  );

  assign head_sel = (kind_q == KIND_READ_ALL) || (head.prio == prio_q);
  assign at_end   = (step_q == count_q - CNT_W'(1));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    found_d     = found_q;
    cmd_op      = OP_HOLD;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_data   = '0;
    emit_prio   = '0;
    emit_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
          step_d  = '0;
          found_d = 1'b0;
        end
      end
      S_EXEC: begin
        if (can_emit) begin
          state_d = S_IDLE;
          case (kind_q)
            KIND_INSERT: begin
              emit = 1'b1;
              if (count_q == FULL_COUNT) begin
                emit_status = ST_FULL;
              end else begin
                cmd_op  = OP_INSERT;
                count_d = count_q + CNT_W'(1);
              end
            end
            KIND_DEL_GROUP: begin
              if (count_q == '0) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                state_d = S_GROUP;
              end
            end
            KIND_DEL_MATCH: begin
              emit = 1'b1;
              if (count_q == '0) begin
                emit_status = ST_EMPTY;
              end else if (hit) begin
                cmd_op  = OP_REMOVE;
                count_d = count_q - CNT_W'(1);
              end else begin
                emit_status = ST_NOT_FOUND;
              end
            end
            KIND_CLEAR: begin
              emit        = 1'b1;
              cmd_op      = OP_CLEAR;
              count_d     = '0;
              emit_status = (count_q == '0) ? ST_EMPTY : ST_OK;
            end
            KIND_READ_ALL, KIND_READ_PRIO: begin
              if (count_q == '0) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else if (kind_q == KIND_READ_PRIO && !hit) begin
                emit        = 1'b1;
                emit_status = ST_NOT_FOUND;
              end else begin
                state_d = S_ROT;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_GROUP: begin
        // One entry of the group leaves per cycle until none is left.
        if (hit) begin
          cmd_op  = OP_REMOVE;
          count_d = count_q - CNT_W'(1);
          found_d = 1'b1;
        end else if (can_emit) begin
          emit        = 1'b1;
          emit_status = found_q ? ST_OK : ST_NOT_FOUND;
          state_d     = S_IDLE;
        end
      end
      S_ROT: begin
        // After count rotations every entry is back in its own cell.
        if (can_emit) begin
          cmd_op    = OP_ROTATE;
          emit      = head_sel;
          emit_data = head.data;
          emit_prio = head.prio;
          emit_last = at_end || (kind_q == KIND_READ_PRIO && second.prio != prio_q);
          step_d    = step_q + CNT_W'(1);
          if (at_end) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      found_q <= found_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= in_i.kind;
      data_q <= in_i.item_data;
      prio_q <= in_i.item_priority;
    end
    if (emit) begin
      out_status_q <= emit_status;
      out_data_q   <= emit_data;
      out_prio_q   <= emit_prio;
      out_count_q  <= count_d;
      out_last_q   <= emit_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.out_data     = out_data_q;
  assign out_o.out_priority = out_prio_q;
  assign out_o.entry_count  = out_count_q;
  assign out_o.last         = out_last_q;

endmodule

/* design/sspq_checker.sv */
// ----------------------------------------------------------------------------
// Stable sorted priority queue checker
// Watches the result channel of the queue for inconsistent words.
// ----------------------------------------------------------------------------
module sspq_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  out_valid_i,
  input logic                                  out_ready_i,
  input logic [sspq_pkg::STATUS_W-1:0]         status_i,
  input logic signed [sspq_pkg::DATA_WIDTH-1:0] out_data_i,
  input logic [sspq_pkg::PRIORITY_WIDTH-1:0]   out_priority_i,
  input logic [sspq_pkg::CNT_W-1:0]            entry_count_i,
  input logic                                  last_i
);
  import sspq_pkg::*;

  // A stalled word stays on the channel unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
    $stable(out_data_i) && $stable(out_priority_i) && $stable(entry_count_i) &&
    $stable(last_i))
    else $error("result word changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> entry_count_i <= CNT_W'(DEPTH))
    else $error("entry count above queue depth");

  // Only listed entries of a read come in runs, and those always succeed.
  a_run_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> status_i == ST_OK)
    else $error("non-final word without ok status");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |->
    out_data_i == '0 && out_priority_i == '0 && last_i)
    else $error("failing status with payload or not final");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_EMPTY |-> entry_count_i == '0)
    else $error("empty status with entries held");

endmodule

bind stable_sorted_priority_queue_unit sspq_checker u_sspq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .out_data_i     (out_o.out_data),
  .out_priority_i (out_o.out_priority),
  .entry_count_i  (out_o.entry_count),
  .last_i         (out_o.last)
);

/* sim/tb_stable_sorted_priority_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable sorted priority queue testbench
// Sends directed and random requests through the valid/ready request channel
// and checks every result word against a sorted-list model kept in the bench.
// The run covers four idling phases and waits for every outstanding word between them.
// ----------------------------------------------------------------------------
module tb_stable_sorted_priority_queue_unit;
  import sspq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 20;
  localparam int unsigned DRAIN_CYCLES = 40;

  // The kind field has two codes that the block treats as no-ops.
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

  typedef struct {
    logic [KIND_W-1:0]                kind;
    logic signed [DATA_WIDTH-1:0]     data;
    logic        [PRIORITY_WIDTH-1:0] prio;
  } request_t;

  typedef struct {
    logic signed [DATA_WIDTH-1:0]     data;
    logic        [PRIORITY_WIDTH-1:0] prio;
  } slot_t;

  typedef struct {
    status_e                          status;
    logic signed [DATA_WIDTH-1:0]     data;
    logic        [PRIORITY_WIDTH-1:0] prio;
    logic        [CNT_W-1:0]          count;
    logic                             last;
  } result_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sspq_in_if  req_if ();
  sspq_out_if rsp_if ();

  stable_sorted_priority_queue_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  request_t     pending_q[$];
  slot_t        queue_model[$];
  result_word_t expected_words[$];
  slot_t        inserted_q[$];

  request_t     next_req;
  result_word_t exp_word;
  logic [PRIORITY_WIDTH-1:0] prio_pool[4];

  int unsigned send_idle_pct = 0;
  int unsigned ready_stall_pct = 0;
  int unsigned n_errors = 0;
  int unsigned n_requests = 0;
  int unsigned n_words = 0;
  int unsigned n_listed = 0;
  int unsigned n_full = 0;
  int unsigned n_not_found = 0;
  int unsigned n_empty = 0;
  int unsigned cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void expect_word(status_e st, logic signed [DATA_WIDTH-1:0] d,
                                      logic [PRIORITY_WIDTH-1:0] p, logic last);
    result_word_t w;
    w.status = st;
    w.data   = d;
    w.prio   = p;
    w.count  = CNT_W'(queue_model.size());
    w.last   = last;
    expected_words.push_back(w);
  endfunction

  // Applies one request to the sorted list and queues the result words it causes.
  function automatic void apply_request(logic [KIND_W-1:0] kind, logic signed [DATA_WIDTH-1:0] d,
                                        logic [PRIORITY_WIDTH-1:0] p);
    int      pos;
    int      listed;
    int      first_hit;
    status_e st;
    slot_t   kept[$];
    slot_t   s;
    st = ST_OK;
    case (kind)
      KIND_INSERT: begin
        if (queue_model.size() >= DEPTH) begin
          st = ST_FULL;
        end else begin
          pos = queue_model.size();
          for (int i = queue_model.size() - 1; i >= 0; i--) begin
            if (queue_model[i].prio > p) pos = i;
          end
          s.data = d;
          s.prio = p;
          queue_model.insert(pos, s);
        end
      end
      KIND_DEL_GROUP: begin
        if (queue_model.size() == 0) begin
          st = ST_EMPTY;
        end else begin
          foreach (queue_model[i]) begin
            if (queue_model[i].prio != p) kept.push_back(queue_model[i]);
          end
          if (kept.size() == queue_model.size()) st = ST_NOT_FOUND;
          queue_model = kept;
        end
      end
      KIND_DEL_MATCH: begin
        if (queue_model.size() == 0) begin
          st = ST_EMPTY;
        end else begin
          first_hit = -1;
          for (int i = queue_model.size() - 1; i >= 0; i--) begin
            if (queue_model[i].prio == p && queue_model[i].data == d) first_hit = i;
          end
          if (first_hit < 0) st = ST_NOT_FOUND;
          else queue_model.delete(first_hit);
        end
      end
      KIND_CLEAR: begin
        if (queue_model.size() == 0) st = ST_EMPTY;
        queue_model.delete();
      end
      KIND_READ_ALL, KIND_READ_PRIO: begin
        if (queue_model.size() == 0) begin
          expect_word(ST_EMPTY, '0, '0, 1'b1);
          return;
        end
        listed = 0;
        foreach (queue_model[i]) begin
          if (kind == KIND_READ_ALL || queue_model[i].prio == p) begin
            expect_word(ST_OK, queue_model[i].data, queue_model[i].prio, 1'b0);
            listed++;
          end
        end
        n_listed += listed;
        if (listed == 0) expect_word(ST_NOT_FOUND, '0, '0, 1'b1);
        else expected_words[expected_words.size() - 1].last = 1'b1;
        return;
      end
      default: ;
    endcase
    expect_word(st, '0, '0, 1'b1);
  endfunction

  // Queues a request and keeps a rough list of stored pairs so that random
  // match deletes usually hit something.
  function automatic void add_request(logic [KIND_W-1:0] kind, logic signed [DATA_WIDTH-1:0] d,
                                      logic [PRIORITY_WIDTH-1:0] p);
    request_t r;
    slot_t    s;
    slot_t    kept[$];
    int       hit;
    r.kind = kind;
    r.data = d;
    r.prio = p;
    pending_q.push_back(r);
    s.data = d;
    s.prio = p;
    case (kind)
      KIND_INSERT: if (inserted_q.size() < DEPTH) inserted_q.push_back(s);
      KIND_DEL_MATCH: begin
        hit = -1;
        for (int i = inserted_q.size() - 1; i >= 0; i--) begin
          if (inserted_q[i].data == d && inserted_q[i].prio == p) hit = i;
        end
        if (hit >= 0) inserted_q.delete(hit);
      end
      KIND_DEL_GROUP: begin
        foreach (inserted_q[i]) begin
          if (inserted_q[i].prio != p) kept.push_back(inserted_q[i]);
        end
        inserted_q = kept;
      end
      KIND_CLEAR: inserted_q.delete();
      default: ;
    endcase
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] rand_data();
    logic signed [DATA_WIDTH-1:0] d;
    d = DATA_WIDTH'($urandom);
    if ($urandom_range(9) < 3) begin
      case ($urandom_range(3))
        0: d = 16'sh7FFF;
        1: d = 16'sh8000;
        2: d = 16'shFFFF;
        default: d = 16'sh0000;
      endcase
    end
    return d;
  endfunction

  function automatic logic [PRIORITY_WIDTH-1:0] rand_prio();
    if ($urandom_range(9) < 8) return prio_pool[$urandom_range(3)];
    return PRIORITY_WIDTH'($urandom_range(255));
  endfunction

  task automatic queue_random_requests(input int unsigned n);
    int unsigned pick;
    int unsigned idx;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        add_request(KIND_INSERT, rand_data(), rand_prio());
      end else if (pick < 60) begin
        if (inserted_q.size() != 0 && $urandom_range(4) != 0) begin
          idx = $urandom_range(inserted_q.size() - 1);
          add_request(KIND_DEL_MATCH, inserted_q[idx].data, inserted_q[idx].prio);
        end else begin
          add_request(KIND_DEL_MATCH, rand_data(), rand_prio());
        end
      end else if (pick < 67) begin
        add_request(KIND_DEL_GROUP, rand_data(), rand_prio());
      end else if (pick < 70) begin
        add_request(KIND_CLEAR, rand_data(), rand_prio());
      end else if (pick < 80) begin
        add_request(KIND_READ_ALL, rand_data(), rand_prio());
      end else if (pick < 94) begin
        add_request(KIND_READ_PRIO, rand_data(), rand_prio());
      end else if (pick < 97) begin
        add_request(KIND_SPARE_A, rand_data(), rand_prio());
      end else begin
        add_request(KIND_SPARE_B, rand_data(), rand_prio());
      end
    end
  endtask

  // The sender holds off here until every expected word has come back.
  task automatic wait_until_drained();
    while (pending_q.size() != 0 || req_if.valid || expected_words.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid         <= 1'b0;
      req_if.kind          <= KIND_INSERT;
      req_if.item_data     <= '0;
      req_if.item_priority <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_q.pop_front();
        req_if.valid         <= 1'b1;
        req_if.kind          <= next_req.kind;
        req_if.item_data     <= next_req.data;
        req_if.item_priority <= next_req.prio;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        n_words++;
        if (expected_words.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("%0t: unexpected word: status=%0d data=%0d prio=%0d count=%0d last=%0b",
                     $time, rsp_if.status, rsp_if.out_data, rsp_if.out_priority,
                     rsp_if.entry_count, rsp_if.last);
          end
        end else begin
          exp_word = expected_words.pop_front();
          case (exp_word.status)
            ST_FULL:      n_full++;
            ST_NOT_FOUND: n_not_found++;
            ST_EMPTY:     n_empty++;
            default:      ;
          endcase
          if (rsp_if.status !== exp_word.status || rsp_if.out_data !== exp_word.data ||
              rsp_if.out_priority !== exp_word.prio || rsp_if.entry_count !== exp_word.count ||
              rsp_if.last !== exp_word.last) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
              $display("%0t: mismatch: expected status=%0d data=%0d prio=%0d count=%0d last=%0b",
                       $time, exp_word.status, exp_word.data, exp_word.prio, exp_word.count,
                       exp_word.last);
              $display("%0t:           got      status=%0d data=%0d prio=%0d count=%0d last=%0b",
                       $time, rsp_if.status, rsp_if.out_data, rsp_if.out_priority,
                       rsp_if.entry_count, rsp_if.last);
            end
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        n_requests++;
        apply_request(req_if.kind, req_if.item_data, req_if.item_priority);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words still outstanding", $time, expected_words.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b1;
    #1 rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty-queue statuses, the no-op kinds, extremes and equal priorities.
    add_request(KIND_READ_ALL, 16'sh0000, 8'd0);
    add_request(KIND_READ_PRIO, 16'sh0000, 8'd5);
    add_request(KIND_DEL_GROUP, 16'sh0000, 8'd5);
    add_request(KIND_DEL_MATCH, 16'sh0001, 8'd5);
    add_request(KIND_CLEAR, 16'sh0000, 8'd0);
    add_request(KIND_SPARE_A, 16'shFFFF, 8'hFF);
    add_request(KIND_SPARE_B, 16'sh5A5A, 8'hA5);
    add_request(KIND_INSERT, 16'sh7FFF, 8'hFF);
    add_request(KIND_INSERT, 16'sh8000, 8'h00);
    add_request(KIND_INSERT, 16'sh0000, 8'hFF);
    add_request(KIND_INSERT, 16'shFFFF, 8'h80);
    add_request(KIND_INSERT, 16'sh1234, 8'h80);
    add_request(KIND_READ_ALL, 16'sh0000, 8'd0);
    add_request(KIND_READ_PRIO, 16'sh0000, 8'hFF);
    add_request(KIND_READ_PRIO, 16'sh0000, 8'd7);
    add_request(KIND_DEL_MATCH, 16'sh8000, 8'hFF);
    add_request(KIND_DEL_MATCH, 16'sh7FFF, 8'hFF);
    add_request(KIND_DEL_GROUP, 16'sh0000, 8'd9);
    add_request(KIND_DEL_GROUP, 16'sh0000, 8'h80);
    add_request(KIND_READ_ALL, 16'sh0000, 8'd0);
    add_request(KIND_CLEAR, 16'sh0000, 8'd0);
    wait_until_drained();

    // Fill past capacity so that inserts get dropped and a read lists all slots.
    prio_pool[0] = 8'h00;
    prio_pool[1] = 8'hFF;
    prio_pool[2] = 8'($urandom_range(255));
    prio_pool[3] = 8'($urandom_range(255));
    repeat (DEPTH + 2) add_request(KIND_INSERT, rand_data(), rand_prio());
    add_request(KIND_READ_ALL, 16'sh0000, 8'd0);
    add_request(KIND_READ_PRIO, 16'sh0000, prio_pool[0]);

    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk_i);
      case (ph)
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 79; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 79; end
        default: begin send_idle_pct = 26; ready_stall_pct = 26; end
      endcase
      if (ph != 0) begin
        foreach (prio_pool[i]) prio_pool[i] = 8'($urandom_range(255));
      end
      queue_random_requests(55);
      wait_until_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Sent %0d requests over four idling phases and checked %0d result words.",
             n_requests, n_words);
    $display("Listed %0d entries; saw %0d full drops, %0d not-found and %0d empty statuses.",
             n_listed, n_full, n_not_found, n_empty);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/sspq_pkg.sv
design/sspq_if.sv
design/sspq_cell.sv
design/sspq_chain.sv
design/stable_sorted_priority_queue_unit.sv
design/sspq_checker.sv
sim/tb_stable_sorted_priority_queue_unit.sv
